// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define TTRR_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("ttrr assertion failed");

`define TTRR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ttrr assertion failed");

`else

`define TTRR_ASSERT(label, clk, rst_n, prop)

`define TTRR_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/ttrr_pkg.sv =====
package ttrr_pkg;

  localparam logic [1:0] ST_READY      = 2'd0;
  localparam logic [1:0] ST_RUNNING    = 2'd1;
  localparam logic [1:0] ST_BLOCKED    = 2'd2;
  localparam logic [1:0] ST_TERMINATED = 2'd3;

  localparam logic [2:0] REQ_TICK = 3'd0;
  localparam logic [2:0] REQ_ADD  = 3'd1;
  localparam logic [2:0] REQ_FORK = 3'd2;
  localparam logic [2:0] REQ_EXIT = 3'd3;
  localparam logic [2:0] REQ_WAIT = 3'd4;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_FULL = 2'd1;
  localparam logic [1:0] STAT_NONE = 2'd2;

  typedef struct packed {
    logic [1:0] run_state;
    logic [7:0] parent_slot;
    logic       waited_mark;
  } ent_t;

  typedef struct packed {
    logic is_ready;
    logic is_running;
    logic is_blocked;
    logic is_term;
    logic child;
    logic waited_child;
  } match_t;

endpackage

// ===== rtl/ttrr_table.sv =====
module ttrr_table #(
  parameter int DEPTH = 256,
  parameter int IW    = 8
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [IW-1:0]    waddr_i,
  input  ttrr_pkg::ent_t   wdata_i,
  input  logic [IW-1:0]    raddr_i,
  output ttrr_pkg::ent_t   rdata_o
);
  import ttrr_pkg::*;

  ent_t mem [DEPTH];
  ent_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/ttrr_match.sv =====
module ttrr_match #(
  parameter int IW = 8
) (
  input  ttrr_pkg::ent_t   ent_i,
  input  logic [IW-1:0]    pos_i,
  input  logic [IW-1:0]    key_slot_i,
  input  logic [7:0]       key_par_i,
  output ttrr_pkg::match_t match_o
);
  import ttrr_pkg::*;

  logic child;

  assign child = (pos_i != key_slot_i) && (ent_i.parent_slot == key_par_i) &&
                 (ent_i.run_state != ST_TERMINATED);

  always_comb begin
    match_o.is_ready     = ent_i.run_state == ST_READY;
    match_o.is_running   = ent_i.run_state == ST_RUNNING;
    match_o.is_blocked   = ent_i.run_state == ST_BLOCKED;
    match_o.is_term      = ent_i.run_state == ST_TERMINATED;
    match_o.child        = child;
    match_o.waited_child = child && ent_i.waited_mark;
  end

endmodule

// ===== rtl/task_table_round_robin_scheduler_top.sv =====
// Add, full-table and unknown requests: result registered in the cycle after start, busy stays low.
// Tick, wait and exit may scan the table; fork reads the current task and then appends the child.
// The table scan reads one entry per cycle from a memory with one read port and one write port.
// One request at a time; a result is shown for one cycle and cannot be held off.
// Reset clears the task count and current task; table entries are not cleared,
// and entries at or above the task count are never read.
`include "assert_macros.svh"

module task_table_round_robin_scheduler_top #(
  parameter int NUM_SLOTS = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] req_type_i,
  input  logic [7:0] parent_id_i,
  output logic       done_o,
  output logic [1:0] status_o,
  output logic [7:0] task_index_o,
  output logic       task_valid_o
);
  import ttrr_pkg::*;

  localparam int IW  = (NUM_SLOTS > 2) ? $clog2(NUM_SLOTS) : 1;
  localparam int CW  = IW + 1;
  localparam int PW  = (IW > 8) ? IW : 8;
  localparam int CPW = (CW > 8) ? CW : 8;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_TCUR = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_CUR  = 3'd3;
  localparam logic [2:0] S_EPRD = 3'd4;
  localparam logic [2:0] S_EPAR = 3'd5;

  logic [2:0]    state_q, state_d;
  logic [2:0]    req_q, req_d;
  logic [IW-1:0] cur_q, cur_d;
  logic          cur_valid_q, cur_valid_d;
  logic [CW-1:0] count_q, count_d;
  logic [IW-1:0] addr_q, addr_d;
  logic [CW-1:0] issued_q, issued_d;
  logic          pend_q, pend_d;
  logic [IW-1:0] pend_pos_q, pend_pos_d;
  logic          flag_q, flag_d;
  logic [IW-1:0] key_slot_q, key_slot_d;
  logic [7:0]    key_par_q, key_par_d;
  ent_t          w_q, w_d;
  logic          done_q, done_d;
  logic [1:0]    status_q, status_d;
  logic [7:0]    index_q, index_d;
  logic          tvalid_q, tvalid_d;

  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  ent_t          mem_wdata;
  logic [IW-1:0] mem_raddr;
  ent_t          rd_data;
  match_t        m;

  logic [PW-1:0]  cur_ext, cnt_ext, pend_ext, par_ext;
  logic [CW-1:0]  addr_inc, cur_inc;
  logic [CPW-1:0] par_cmp, cnt_cmp;
  logic           full, have_cur;

  ttrr_table #(.DEPTH(NUM_SLOTS), .IW(IW)) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (rd_data)
  );

  ttrr_match #(.IW(IW)) u_match (
    .ent_i      (rd_data),
    .pos_i      (pend_pos_q),
    .key_slot_i (key_slot_q),
    .key_par_i  (key_par_q),
    .match_o    (m)
  );

  assign cur_ext  = PW'(cur_q);
  assign cnt_ext  = PW'(count_q);
  assign pend_ext = PW'(pend_pos_q);
  assign par_ext  = PW'(rd_data.parent_slot);
  assign par_cmp  = CPW'(rd_data.parent_slot);
  assign cnt_cmp  = CPW'(count_q);
  assign addr_inc = {1'b0, addr_q} + CW'(1);
  assign cur_inc  = {1'b0, cur_q} + CW'(1);
  assign full     = count_q >= CW'(NUM_SLOTS);
  assign have_cur = cur_valid_q && ({1'b0, cur_q} < count_q);

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    cur_d       = cur_q;
    cur_valid_d = cur_valid_q;
    count_d     = count_q;
    addr_d      = addr_q;
    issued_d    = issued_q;
    pend_d      = 1'b0;
    pend_pos_d  = pend_pos_q;
    flag_d      = flag_q;
    key_slot_d  = key_slot_q;
    key_par_d   = key_par_q;
    w_d         = w_q;
    done_d      = 1'b0;
    status_d    = status_q;
    index_d     = index_q;
    tvalid_d    = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = cur_q;
    mem_wdata   = w_q;
    mem_raddr   = addr_q;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          req_d    = req_type_i;
          status_d = STAT_OK;
          index_d  = 8'h00;
          issued_d = '0;
          flag_d   = 1'b0;
          case (req_type_i)
            REQ_TICK: begin
              if (count_q == '0) begin
                done_d   = 1'b1;
                status_d = STAT_NONE;
              end else if (have_cur) begin
                mem_raddr = cur_q;
                state_d   = S_TCUR;
              end else begin
                addr_d  = '0;
                state_d = S_SCAN;
              end
            end
            REQ_ADD: begin
              done_d = 1'b1;
              if (full) begin
                status_d = STAT_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = count_q[IW-1:0];
                mem_wdata = '{run_state: ST_READY, parent_slot: parent_id_i,
                              waited_mark: 1'b0};
                count_d   = count_q + CW'(1);
                index_d   = cnt_ext[7:0];
                tvalid_d  = 1'b1;
              end
            end
            REQ_FORK, REQ_EXIT, REQ_WAIT: begin
              if (req_type_i == REQ_FORK && full) begin
                done_d   = 1'b1;
                status_d = STAT_FULL;
              end else if (!have_cur) begin
                done_d   = 1'b1;
                status_d = STAT_NONE;
              end else begin
                mem_raddr = cur_q;
                state_d   = S_CUR;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end

      S_TCUR: begin
        if (rd_data.run_state == ST_RUNNING) begin
          mem_we    = 1'b1;
          mem_waddr = cur_q;
          mem_wdata = '{run_state: ST_READY, parent_slot: rd_data.parent_slot,
                        waited_mark: rd_data.waited_mark};
        end
        addr_d  = (cur_inc == count_q) ? '0 : cur_inc[IW-1:0];
        state_d = S_SCAN;
      end

      S_CUR: begin
        w_d = rd_data;
        if (m.is_term) begin
          done_d   = 1'b1;
          status_d = STAT_NONE;
          state_d  = S_IDLE;
        end else begin
          case (req_q)
            REQ_FORK: begin
              mem_we    = 1'b1;
              mem_waddr = count_q[IW-1:0];
              mem_wdata = '{run_state: ST_READY, parent_slot: cur_ext[7:0],
                            waited_mark: 1'b0};
              count_d   = count_q + CW'(1);
              done_d    = 1'b1;
              index_d   = cnt_ext[7:0];
              tvalid_d  = 1'b1;
              state_d   = S_IDLE;
            end
            REQ_EXIT: begin
              mem_we     = 1'b1;
              mem_waddr  = cur_q;
              mem_wdata  = '{run_state: ST_TERMINATED,
                             parent_slot: rd_data.parent_slot, waited_mark: 1'b0};
              key_par_d  = rd_data.parent_slot;
              key_slot_d = par_ext[IW-1:0];
              if (rd_data.waited_mark && (par_cmp < cnt_cmp)) begin
                state_d = S_EPRD;
              end else begin
                done_d  = 1'b1;
                state_d = S_IDLE;
              end
            end
            default: begin
              key_par_d  = cur_ext[7:0];
              key_slot_d = cur_q;
              addr_d     = '0;
              state_d    = S_SCAN;
            end
          endcase
        end
      end

      S_EPRD: begin
        mem_raddr = key_slot_q;
        state_d   = S_EPAR;
      end

      S_EPAR: begin
        w_d = rd_data;
        if (m.is_blocked) begin
          addr_d  = '0;
          state_d = S_SCAN;
        end else begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end

      S_SCAN: begin
        if (issued_q != count_q) begin
          mem_raddr  = addr_q;
          addr_d     = (addr_inc == count_q) ? '0 : addr_inc[IW-1:0];
          issued_d   = issued_q + CW'(1);
          pend_d     = 1'b1;
          pend_pos_d = addr_q;
        end
        if (pend_q) begin
          case (req_q)
            REQ_TICK: begin
              if (m.is_ready) begin
                mem_we      = 1'b1;
                mem_waddr   = pend_pos_q;
                mem_wdata   = '{run_state: ST_RUNNING, parent_slot: rd_data.parent_slot,
                                waited_mark: rd_data.waited_mark};
                cur_d       = pend_pos_q;
                cur_valid_d = 1'b1;
                done_d      = 1'b1;
                index_d     = pend_ext[7:0];
                tvalid_d    = 1'b1;
                state_d     = S_IDLE;
              end
            end
            REQ_EXIT: begin
              if (m.waited_child) begin
                flag_d = 1'b1;
              end
            end
            default: begin
              if (m.child) begin
                mem_we    = 1'b1;
                mem_waddr = pend_pos_q;
                mem_wdata = '{run_state: rd_data.run_state,
                              parent_slot: rd_data.parent_slot, waited_mark: 1'b1};
                flag_d    = 1'b1;
              end
            end
          endcase
        end else if (issued_q == count_q) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
          case (req_q)
            REQ_TICK: begin
              status_d = STAT_NONE;
            end
            REQ_EXIT: begin
              if (!flag_q) begin
                mem_we    = 1'b1;
                mem_waddr = key_slot_q;
                mem_wdata = '{run_state: ST_READY, parent_slot: w_q.parent_slot,
                              waited_mark: w_q.waited_mark};
              end
            end
            default: begin
              if (flag_q) begin
                mem_we    = 1'b1;
                mem_waddr = cur_q;
                mem_wdata = '{run_state: ST_BLOCKED, parent_slot: w_q.parent_slot,
                              waited_mark: w_q.waited_mark};
              end
            end
          endcase
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      req_q       <= REQ_TICK;
      cur_q       <= '0;
      cur_valid_q <= 1'b0;
      count_q     <= '0;
      issued_q    <= '0;
      pend_q      <= 1'b0;
      flag_q      <= 1'b0;
      done_q      <= 1'b0;
      tvalid_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      req_q       <= req_d;
      cur_q       <= cur_d;
      cur_valid_q <= cur_valid_d;
      count_q     <= count_d;
      issued_q    <= issued_d;
      pend_q      <= pend_d;
      flag_q      <= flag_d;
      done_q      <= done_d;
      tvalid_q    <= tvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q     <= addr_d;
    pend_pos_q <= pend_pos_d;
    key_slot_q <= key_slot_d;
    key_par_q  <= key_par_d;
    w_q        <= w_d;
    status_q   <= status_d;
    index_q    <= index_d;
  end

  assign busy         = state_q != S_IDLE;
  assign done_o       = done_q;
  assign status_o     = status_q;
  assign task_index_o = index_q;
  assign task_valid_o = tvalid_q;

  `TTRR_ASSERT(a_done_after_req, clk_i, rst_ni, done_o |-> $past(busy || start))
  `TTRR_ASSERT(a_valid_ok, clk_i, rst_ni, task_valid_o |-> (done_o && status_o == STAT_OK))
  `TTRR_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CW'(NUM_SLOTS))
  `TTRR_ASSERT_NEXT(a_cur_in_table, clk_i, rst_ni, cur_valid_q, have_cur)

endmodule
